[rtl/complex_arith_unit_macros.svh]
// Assertion macros for the complex arithmetic unit.
// No dependencies; included by files that carry assertions.
`ifndef COMPLEX_ARITH_UNIT_MACROS_SVH
`define COMPLEX_ARITH_UNIT_MACROS_SVH

// Clocked check, disabled while reset is high
`define CAU_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked implication check, disabled while reset is high
`define CAU_ASSERT_IMP(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

`endif

[rtl/cau_pkg.sv]
// Package for the complex arithmetic unit: widths, operation codes, payload types.
// No dependencies.
package cau_pkg;

   localparam int DATA_WIDTH   = 32;
   localparam int FRAC_BITS    = 16;
   localparam int THRESH_WIDTH = 16;
   localparam int PROD_WIDTH   = 2 * DATA_WIDTH;
   localparam int SUM_WIDTH    = PROD_WIDTH + 1;
   localparam int NUM_WIDTH    = SUM_WIDTH + FRAC_BITS;

   localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = 16'd6554;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef struct packed {
      op_type                        operation;
      logic signed [DATA_WIDTH-1:0]  a_re;
      logic signed [DATA_WIDTH-1:0]  a_im;
      logic signed [DATA_WIDTH-1:0]  b_re;
      logic signed [DATA_WIDTH-1:0]  b_im;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0]  res_re;
      logic signed [DATA_WIDTH-1:0]  res_im;
      logic                          overflow;
      logic                          divide_by_zero;
   } rsp_payload_type;

   // One result component on its way through the divider stages
   typedef struct packed {
      logic                    neg;
      logic                    big;
      logic [PROD_WIDTH-1:0]   rem;
      logic [DATA_WIDTH-1:0]   low;
      logic [DATA_WIDTH-1:0]   quo;
   } lane_type;

   // Item-wide control carried beside the two lanes
   typedef struct packed {
      logic                    is_div;
      logic                    dbz;
      logic [PROD_WIDTH-1:0]   den;
   } meta_type;

endpackage

[rtl/complex_arith_unit.sv]
// Complex add / subtract / multiply / divide in signed fixed point, pipelined.
// Registers in order: input, products, exact sums, divider setup, restoring steps, output.
// Throughput: one item per cycle; the divider is one restoring step per stage.
// The whole pipeline holds while a result waits under rsp_stall.
// Reset (synchronous): all valid bits clear, the flush threshold returns to 6554.
// Depends on cau_pkg and complex_arith_unit_macros.svh.
`include "complex_arith_unit_macros.svh"

module complex_arith_unit
   import cau_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_payload_type          req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_payload_type          rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [THRESH_WIDTH-1:0]  csr_data
);

   // ---------------------------------------------------------------
   // Helpers
   // ---------------------------------------------------------------
   function automatic logic [SUM_WIDTH-1:0] ext_prod(input logic [PROD_WIDTH-1:0] p);
      ext_prod = {p[PROD_WIDTH-1], p};
   endfunction

   // Scale the exact value and set up the divider lane
   function automatic lane_type prep(input logic [SUM_WIDTH-1:0] sum,
                                     input op_type op,
                                     input logic [PROD_WIDTH-1:0] den);
      lane_type               l;
      logic [SUM_WIDTH-1:0]   mag;
      logic [SUM_WIDTH-1:0]   sh;
      logic [NUM_WIDTH-1:0]   num;
      logic [NUM_WIDTH-1:0]   top;
      l.neg = sum[SUM_WIDTH-1];
      mag   = l.neg ? (~sum + 1'b1) : sum;
      sh    = mag >> FRAC_BITS;
      num   = {mag, {FRAC_BITS{1'b0}}};
      top   = num >> DATA_WIDTH;
      l.rem = '0;
      l.low = '0;
      case (op)
         OP_MUL: begin
            l.big = |sh[SUM_WIDTH-1:DATA_WIDTH];
            l.quo = sh[DATA_WIDTH-1:0];
         end
         OP_DIV: begin
            // quotient reaches 2^DATA_WIDTH exactly when num >> DATA_WIDTH >= den
            l.big = top >= NUM_WIDTH'(den);
            l.rem = top[PROD_WIDTH-1:0];
            l.low = num[DATA_WIDTH-1:0];
            l.quo = '0;
         end
         default: begin
            l.big = |mag[SUM_WIDTH-1:DATA_WIDTH];
            l.quo = mag[DATA_WIDTH-1:0];
         end
      endcase
      prep = l;
   endfunction

   // One restoring division step
   function automatic lane_type div_step(input lane_type l, input meta_type m);
      lane_type                o;
      logic [PROD_WIDTH:0]     trial;
      logic [PROD_WIDTH:0]     diff;
      logic                    ge;
      o     = l;
      trial = {l.rem, l.low[DATA_WIDTH-1]};
      diff  = trial - {1'b0, m.den};
      ge    = trial >= {1'b0, m.den};
      if (m.is_div) begin
         o.rem = ge ? diff[PROD_WIDTH-1:0] : trial[PROD_WIDTH-1:0];
         o.low = {l.low[DATA_WIDTH-2:0], 1'b0};
         o.quo = {l.quo[DATA_WIDTH-2:0], ge};
      end
      div_step = o;
   endfunction

   // Saturate, flush, restore sign; returns {overflow, value}
   function automatic logic [DATA_WIDTH:0] settle(input lane_type l,
                                                  input logic [THRESH_WIDTH-1:0] th);
      logic [DATA_WIDTH-1:0]  limit;
      logic [DATA_WIDTH-1:0]  m;
      logic                   sat;
      limit = l.neg ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : {1'b0, {(DATA_WIDTH-1){1'b1}}};
      sat   = l.big || (l.quo > limit);
      m     = sat ? limit : l.quo;
      if (m < DATA_WIDTH'(th)) begin
         m = '0;
      end
      settle = {sat, (l.neg ? (~m + 1'b1) : m)};
   endfunction

   // ---------------------------------------------------------------
   // Flow control: every stage moves unless a result waits
   // ---------------------------------------------------------------
   logic rsp_valid_ff;
   logic adv;
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // Threshold register
   logic [THRESH_WIDTH-1:0] thresh_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_valid && csr_ready) begin
         thresh_ff <= csr_data;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: input register
   // ---------------------------------------------------------------
   logic             v1_ff;
   req_payload_type  s1_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= req_data;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: products and add/sub
   // ---------------------------------------------------------------
   logic signed [PROD_WIDTH-1:0] p_rr_in, p_ii_in, p_ri_in, p_ir_in, p_br_in, p_bi_in;
   logic signed [PROD_WIDTH-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_br_ff, p_bi_ff;
   logic signed [DATA_WIDTH:0]   as_re_in, as_im_in, as_re_ff, as_im_ff;
   logic                         v2_ff;
   op_type                       op2_ff;

   always_comb begin
      p_rr_in = $signed(s1_ff.a_re) * $signed(s1_ff.b_re);
      p_ii_in = $signed(s1_ff.a_im) * $signed(s1_ff.b_im);
      p_ri_in = $signed(s1_ff.a_re) * $signed(s1_ff.b_im);
      p_ir_in = $signed(s1_ff.a_im) * $signed(s1_ff.b_re);
      p_br_in = $signed(s1_ff.b_re) * $signed(s1_ff.b_re);
      p_bi_in = $signed(s1_ff.b_im) * $signed(s1_ff.b_im);
      if (s1_ff.operation == OP_SUB) begin
         as_re_in = $signed(s1_ff.a_re) - $signed(s1_ff.b_re);
         as_im_in = $signed(s1_ff.a_im) - $signed(s1_ff.b_im);
      end else begin
         as_re_in = $signed(s1_ff.a_re) + $signed(s1_ff.b_re);
         as_im_in = $signed(s1_ff.a_im) + $signed(s1_ff.b_im);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         p_rr_ff  <= p_rr_in;
         p_ii_ff  <= p_ii_in;
         p_ri_ff  <= p_ri_in;
         p_ir_ff  <= p_ir_in;
         p_br_ff  <= p_br_in;
         p_bi_ff  <= p_bi_in;
         as_re_ff <= as_re_in;
         as_im_ff <= as_im_in;
         op2_ff   <= s1_ff.operation;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: exact sums per operation, divisor magnitude
   // ---------------------------------------------------------------
   logic [SUM_WIDTH-1:0]  sum_re_in, sum_im_in, sum_re_ff, sum_im_ff;
   logic [PROD_WIDTH-1:0] den_in, den_ff;
   logic                  v3_ff;
   op_type                op3_ff;

   always_comb begin
      den_in = p_br_ff + p_bi_ff;
      case (op2_ff)
         OP_MUL: begin
            sum_re_in = ext_prod(p_rr_ff) - ext_prod(p_ii_ff);
            sum_im_in = ext_prod(p_ri_ff) + ext_prod(p_ir_ff);
         end
         OP_DIV: begin
            sum_re_in = ext_prod(p_rr_ff) + ext_prod(p_ii_ff);
            sum_im_in = ext_prod(p_ir_ff) - ext_prod(p_ri_ff);
         end
         default: begin
            sum_re_in = {{(SUM_WIDTH-DATA_WIDTH-1){as_re_ff[DATA_WIDTH]}}, as_re_ff};
            sum_im_in = {{(SUM_WIDTH-DATA_WIDTH-1){as_im_ff[DATA_WIDTH]}}, as_im_ff};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         sum_re_ff <= sum_re_in;
         sum_im_ff <= sum_im_in;
         den_ff    <= den_in;
         op3_ff    <= op2_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 4 and divider stages: lane index 0 is the setup stage,
   // lane index k+1 holds the result of quotient step k
   // ---------------------------------------------------------------
   lane_type  lane_re_ff [0:DATA_WIDTH];
   lane_type  lane_im_ff [0:DATA_WIDTH];
   meta_type  meta_ff    [0:DATA_WIDTH];
   logic      lv_ff      [0:DATA_WIDTH];
   meta_type  meta0_in;

   always_comb begin
      meta0_in.is_div = (op3_ff == OP_DIV);
      meta0_in.dbz    = (op3_ff == OP_DIV) && (den_ff == '0);
      meta0_in.den    = den_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lv_ff[0] <= 1'b0;
      end else if (adv) begin
         lv_ff[0] <= v3_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         lane_re_ff[0] <= prep(sum_re_ff, op3_ff, den_ff);
         lane_im_ff[0] <= prep(sum_im_ff, op3_ff, den_ff);
         meta_ff[0]    <= meta0_in;
      end
   end

   for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) begin
            lv_ff[k+1] <= 1'b0;
         end else if (adv) begin
            lv_ff[k+1] <= lv_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            lane_re_ff[k+1] <= div_step(lane_re_ff[k], meta_ff[k]);
            lane_im_ff[k+1] <= div_step(lane_im_ff[k], meta_ff[k]);
            meta_ff[k+1]    <= meta_ff[k];
         end
      end
   end

   // ---------------------------------------------------------------
   // Output register: saturate, flush, sign
   // ---------------------------------------------------------------
   rsp_payload_type  rsp_data_ff, rsp_data_in;
   logic [DATA_WIDTH:0] set_re, set_im;

   always_comb begin
      set_re = settle(lane_re_ff[DATA_WIDTH], thresh_ff);
      set_im = settle(lane_im_ff[DATA_WIDTH], thresh_ff);
      if (meta_ff[DATA_WIDTH].dbz) begin
         rsp_data_in.res_re         = '0;
         rsp_data_in.res_im         = '0;
         rsp_data_in.overflow       = 1'b0;
         rsp_data_in.divide_by_zero = 1'b1;
      end else begin
         rsp_data_in.res_re         = set_re[DATA_WIDTH-1:0];
         rsp_data_in.res_im         = set_im[DATA_WIDTH-1:0];
         rsp_data_in.overflow       = set_re[DATA_WIDTH] | set_im[DATA_WIDTH];
         rsp_data_in.divide_by_zero = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= lv_ff[DATA_WIDTH];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `CAU_ASSERT_IMP(a_dbz_zero, rsp_valid_ff && rsp_data_ff.divide_by_zero, rsp_data_ff.res_re == '0 && rsp_data_ff.res_im == '0 && !rsp_data_ff.overflow, "divide by zero result not clean")
   `CAU_ASSERT_IMP(a_hold_on_stall, rsp_valid_ff && rsp_stall, req_stall, "pipeline not held while result waits")
   `CAU_ASSERT(a_last_to_out, (lv_ff[DATA_WIDTH] && adv) |=> rsp_valid_ff, "item lost at output register")

endmodule

[bench/complex_arith_unit_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for complex_arith_unit: complex add/sub/mul/div in Q16.16.
// Depends on cau_pkg; predicts each result in exact wide arithmetic and compares.
module complex_arith_unit_tb;
   import cau_pkg::*;

   localparam int LATENCY = DATA_WIDTH + 4;
   localparam int RANDOM_ITEMS = 1900;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [THRESH_WIDTH-1:0] csr_data = '0;

   complex_arith_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   req_payload_type pending_ops[$];
   rsp_payload_type expected_results[$];
   logic [THRESH_WIDTH-1:0] flush_level = THRESH_RESET;
   int mismatches = 0;
   int results_seen = 0;
   int div_count = 0;
   int sat_count = 0;
   bit idling_on = 1'b1;
   bit req_taken = 1'b0;
   int send_gap = 0;
   int recv_gap = 0;

   // Scale, truncate toward zero, saturate, then flush one component
   function automatic logic [DATA_WIDTH-1:0] settle_component(
      input logic signed [127:0] value, input bit scale_up, input bit scale_down,
      input bit use_den, input logic [127:0] den, inout bit sat);
      logic [127:0] mag;
      logic [127:0] limit;
      logic [127:0] m;
      bit neg;
      neg = value[127];
      mag = neg ? -value : value;
      if (scale_up) mag = mag << FRAC_BITS;
      if (scale_down) mag = mag >> FRAC_BITS;
      if (use_den) mag = mag / den;
      limit = neg ? (128'd1 << (DATA_WIDTH - 1)) : (128'd1 << (DATA_WIDTH - 1)) - 1;
      if (mag > limit) begin
         sat = 1'b1;
         m = limit;
      end else begin
         m = mag;
      end
      if (m < {112'd0, flush_level}) m = '0;
      if (neg) m = -m;
      return m[DATA_WIDTH-1:0];
   endfunction

   function automatic rsp_payload_type predict_result(input req_payload_type op);
      rsp_payload_type r;
      logic signed [127:0] ar, ai, br, bi, re, im;
      logic [127:0] den;
      bit sat;
      sat = 1'b0;
      r = '0;
      ar = op.a_re; ai = op.a_im; br = op.b_re; bi = op.b_im;
      case (op.operation)
         OP_ADD: begin
            r.res_re = settle_component(ar + br, 0, 0, 0, '0, sat);
            r.res_im = settle_component(ai + bi, 0, 0, 0, '0, sat);
         end
         OP_SUB: begin
            r.res_re = settle_component(ar - br, 0, 0, 0, '0, sat);
            r.res_im = settle_component(ai - bi, 0, 0, 0, '0, sat);
         end
         OP_MUL: begin
            r.res_re = settle_component(ar * br - ai * bi, 0, 1, 0, '0, sat);
            r.res_im = settle_component(ar * bi + ai * br, 0, 1, 0, '0, sat);
         end
         default: begin
            den = br * br + bi * bi;
            if (den == 0) begin
               r.divide_by_zero = 1'b1;
            end else begin
               re = ar * br + ai * bi;
               im = ai * br - ar * bi;
               r.res_re = settle_component(re, 1, 0, 1, den, sat);
               r.res_im = settle_component(im, 1, 0, 1, den, sat);
            end
         end
      endcase
      r.overflow = sat;
      return r;
   endfunction

   function automatic logic [DATA_WIDTH-1:0] rand_operand();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(0, 1) ? 32'd0 : 32'hffff_ffff;
         3: return $signed($urandom_range(0, 32'h0003_ffff)) - 32'sh0002_0000;
         4: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_payload_type rand_op();
      req_payload_type p;
      p.operation = op_type'($urandom_range(0, 3));
      p.a_re = rand_operand(); p.a_im = rand_operand();
      p.b_re = rand_operand(); p.b_im = rand_operand();
      if (p.operation == OP_DIV && $urandom_range(0, 19) == 0) begin
         p.b_re = '0; p.b_im = '0;
      end
      return p;
   endfunction

   function automatic req_payload_type make_op(input op_type o, input int ar, input int ai,
                                              input int br, input int bi);
      req_payload_type p;
      p.operation = o; p.a_re = ar; p.a_im = ai; p.b_re = br; p.b_im = bi;
      return p;
   endfunction

   // Driver: feeds pending operations, with random idle bursts
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_ops.size() > 0) begin
            req_data <= pending_ops.pop_front();
            req_valid <= 1'b1;
            if (idling_on && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 8);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall bursts
   always @(negedge clock) begin
      if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_stall <= 1'b1;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
         recv_gap <= $urandom_range(0, 7);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: predict on input transfer, check on result transfer
   always @(posedge clock) begin
      req_taken = !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         expected_results.push_back(predict_result(req_data));
         if (req_data.operation == OP_DIV) div_count++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (rsp_data.overflow) sat_count++;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer %h", rsp_data);
         end else if (rsp_data !== expected_results[0]) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch #%0d: exp re %h im %h ovf %b dbz %b, got re %h im %h ovf %b dbz %b",
                        results_seen, expected_results[0].res_re, expected_results[0].res_im,
                        expected_results[0].overflow, expected_results[0].divide_by_zero,
                        rsp_data.res_re, rsp_data.res_im, rsp_data.overflow,
                        rsp_data.divide_by_zero);
            void'(expected_results.pop_front());
         end else begin
            void'(expected_results.pop_front());
         end
      end
   end

   task automatic drain_all();
      while (pending_ops.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THRESH_WIDTH-1:0] level);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= level;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      flush_level = level;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic queue_random(input int count);
      repeat (count) pending_ops.push_back(rand_op());
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: extremes, every operation, zero divisor, saturation, flushing
      pending_ops.push_back(make_op(OP_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                                    32'h8000_0000));
      pending_ops.push_back(make_op(OP_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                                    32'h8000_0000));
      pending_ops.push_back(make_op(OP_ADD, 32'h0001_0000, 32'h0000_1000, 32'h0000_0800,
                                    32'hffff_f000));
      pending_ops.push_back(make_op(OP_SUB, 32'h0000_1999, 32'h0000_199a, 0, 0));
      pending_ops.push_back(make_op(OP_MUL, 32'h0002_0000, 32'h0003_0000, 32'hffff_0000,
                                    32'h0000_8000));
      pending_ops.push_back(make_op(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                    32'h8000_0000));
      pending_ops.push_back(make_op(OP_MUL, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                                    32'h7fff_ffff));
      pending_ops.push_back(make_op(OP_MUL, 32'hffff_ffff, 0, 32'h0000_0001, 0));
      pending_ops.push_back(make_op(OP_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                                    32'hfffc_0000));
      pending_ops.push_back(make_op(OP_DIV, 32'h0001_0000, 32'h0001_0000, 0, 0));
      pending_ops.push_back(make_op(OP_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 0));
      pending_ops.push_back(make_op(OP_DIV, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                                    32'h8000_0000));
      pending_ops.push_back(make_op(OP_DIV, 32'hffff_ffff, 32'h0000_0001, 0, 32'hffff_ffff));
      pending_ops.push_back(make_op(OP_DIV, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff));
      drain_all();

      // Pressure: sender waits here for every result before the threshold change
      write_threshold(16'd0);
      queue_random(300);
      drain_all();
      write_threshold(16'hffff);
      queue_random(300);
      drain_all();
      write_threshold(16'd1);
      queue_random(300);
      drain_all();
      write_threshold(16'(($urandom_range(0, 65535))));
      queue_random(400);
      drain_all();
      write_threshold(THRESH_RESET);
      queue_random(400);
      // last part with no idling on either side
      while (pending_ops.size() > 0) @(posedge clock);
      idling_on = 1'b0;
      queue_random(200);
      drain_all();

      $display("covered %0d results (%0d divides, %0d saturated) over five flush thresholds",
               results_seen, div_count, sat_count);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule

[complex_arith_unit.f]
+incdir+rtl
rtl/cau_pkg.sv
rtl/complex_arith_unit.sv
bench/complex_arith_unit_tb.sv
